### design/satl_pkg.sv
// shared constants, types and functions for the cache tag lookup
`default_nettype none

package satl_pkg;

    localparam int WAYS      = 4;
    localparam int SETS      = 256;
    localparam int AGE_LIMIT = 8;

    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AGE_W     = $clog2(AGE_LIMIT + 1);
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int OFF_W     = 4;
    localparam int IDX_W     = 4;
    localparam int SHAMT_W   = 5;
    localparam int CNT_W     = 32;
    localparam int LFSR_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;
    localparam int WAY_OUT_W = 2;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1,
        CFG_REPLACE_LRU = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // x^16+x^14+x^13+x^11+1, fibonacci form shifting right
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[LFSR_W-1:1]};
    endfunction

endpackage

`default_nettype wire

### design/satl_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module satl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/set_assoc_cache_tag_lookup_top.sv
// set associative cache tag directory with lru or lfsr random replacement
//
// One address item is taken per clock cycle unless the output stalls; its result goes via stage
// one to the output register. Each set (tag, valid bit and age of every way) is one row of a
// one-write one-read ram with registered read: read on accept, compared and updated in stage one
// and written back as it leaves. A following item on the same set gets the written row forwarded.
// A 256-bit per-set flag, cleared by reset, marks rows ever written; an unmarked row reads as
// empty, so reset needs no clearing pass. Configuration registers are written through
// i_cfg_we/i_cfg_index/i_cfg_data; the user must do so only while idle; nothing enforces it.
`default_nettype none

module set_assoc_cache_tag_lookup_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [satl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [satl_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [satl_pkg::ADDR_W-1:0]     i_address,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_hit,
    output logic      [satl_pkg::WAY_OUT_W-1:0]  o_way,
    output logic                                 o_replaced_valid,
    output logic      [satl_pkg::CNT_W-1:0]      o_hit_total,
    output logic      [satl_pkg::CNT_W-1:0]      o_miss_total
);

    // configuration
    logic [satl_pkg::OFF_W-1:0]   r_offset_bits;
    logic [satl_pkg::IDX_W-1:0]   r_index_bits;
    logic                         r_replace_lru;

    // control state
    logic                         r_s1_valid;
    logic                         r_o_valid;
    logic                         r_byp;
    logic [satl_pkg::SETS-1:0]    r_row_valid;
    logic [satl_pkg::LFSR_W-1:0]  r_lfsr;
    logic [satl_pkg::CNT_W-1:0]   r_hit_cnt;
    logic [satl_pkg::CNT_W-1:0]   r_miss_cnt;

    // payload
    logic [satl_pkg::SET_W-1:0]   r_s1_set;
    logic [satl_pkg::TAG_W-1:0]   r_s1_tag;
    satl_pkg::t_row               r_byp_row;
    logic                         r_hit;
    logic [satl_pkg::WAY_W-1:0]   r_way;
    logic                         r_repl;

    logic                         accept;
    logic                         s1_go;
    logic [satl_pkg::ADDR_W-1:0]  addr_shift;
    logic [15:0]                  idx_mask;
    logic [satl_pkg::SHAMT_W-1:0] tag_shamt;
    logic [satl_pkg::SET_W-1:0]   in_set;
    logic [satl_pkg::TAG_W-1:0]   in_tag;
    logic [satl_pkg::ROW_W-1:0]   ram_q;

    satl_pkg::t_row               row_in;
    satl_pkg::t_row               n_row;
    logic                         hit;
    logic [satl_pkg::WAY_W-1:0]   hit_way;
    logic                         inv_found;
    logic [satl_pkg::WAY_W-1:0]   inv_way;
    logic [satl_pkg::AGE_W-1:0]   aged_age [satl_pkg::WAYS];
    logic [satl_pkg::WAY_W-1:0]   oldest;
    logic [satl_pkg::LFSR_W-1:0]  lfsr_adv;
    logic [satl_pkg::WAY_W-1:0]   rnd_start;
    logic [satl_pkg::WAY_W-1:0]   rnd_cand;
    logic                         rnd_found;
    logic [satl_pkg::WAY_W-1:0]   rnd_way;
    logic [satl_pkg::WAY_W-1:0]   sel_way;
    logic                         repl;
    logic [satl_pkg::LFSR_W-1:0]  n_lfsr;
    logic [satl_pkg::CNT_W-1:0]   n_hit_cnt;
    logic [satl_pkg::CNT_W-1:0]   n_miss_cnt;

    assign accept  = i_valid && o_ready;
    assign s1_go   = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_go;

    // address split
    assign addr_shift = i_address >> r_offset_bits;
    assign idx_mask   = 16'((17'd1 << r_index_bits) - 17'd1);
    assign in_set     = addr_shift[satl_pkg::SET_W-1:0] & idx_mask[satl_pkg::SET_W-1:0];
    assign tag_shamt  = satl_pkg::SHAMT_W'(r_offset_bits) + satl_pkg::SHAMT_W'(r_index_bits);
    assign in_tag     = satl_pkg::TAG_W'(i_address >> tag_shamt);

    satl_ram #(
        .WIDTH (satl_pkg::ROW_W),
        .DEPTH (satl_pkg::SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_set),
        .i_wdata (n_row),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (ram_q)
    );

    // lookup and replacement on the fetched row
    always_comb begin
        logic [satl_pkg::AGE_W-1:0] age_one;
        age_one = satl_pkg::AGE_W'(1);

        if (r_byp) begin
            row_in = r_byp_row;
        end else if (r_row_valid[r_s1_set]) begin
            row_in = satl_pkg::t_row'(ram_q);
        end else begin
            row_in = '0;
        end

        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < satl_pkg::WAYS; w++) begin
            if (!hit && row_in[w].valid && row_in[w].tag == r_s1_tag) begin
                hit     = 1'b1;
                hit_way = satl_pkg::WAY_W'(w);
            end
        end

        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = 0; w < satl_pkg::WAYS; w++) begin
            if (!inv_found && !row_in[w].valid) begin
                inv_found = 1'b1;
                inv_way   = satl_pkg::WAY_W'(w);
            end
        end

        // every valid way except the hit one ages, saturating
        for (int w = 0; w < satl_pkg::WAYS; w++) begin
            aged_age[w] = row_in[w].age;
            if (row_in[w].valid && row_in[w].age < satl_pkg::AGE_W'(satl_pkg::AGE_LIMIT)
                && !(hit && hit_way == satl_pkg::WAY_W'(w))) begin
                aged_age[w] = row_in[w].age + age_one;
            end
        end

        // greatest age, ties to the highest way
        oldest = '0;
        for (int w = 0; w < satl_pkg::WAYS; w++) begin
            if (aged_age[w] >= aged_age[oldest]) begin
                oldest = satl_pkg::WAY_W'(w);
            end
        end

        // random victim: first invalid way at or after start, wrapping
        lfsr_adv  = satl_pkg::lfsr_next(r_lfsr);
        rnd_start = lfsr_adv[satl_pkg::WAY_W-1:0];
        rnd_found = 1'b0;
        rnd_way   = rnd_start;
        for (int k = 0; k < satl_pkg::WAYS; k++) begin
            rnd_cand = rnd_start + satl_pkg::WAY_W'(k);
            if (!rnd_found && !row_in[rnd_cand].valid) begin
                rnd_found = 1'b1;
                rnd_way   = rnd_cand;
            end
        end

        n_row  = row_in;
        n_lfsr = r_lfsr;
        if (hit) begin
            sel_way = hit_way;
            repl    = 1'b0;
            if (r_replace_lru) begin
                for (int w = 0; w < satl_pkg::WAYS; w++) begin
                    n_row[w].age = aged_age[w];
                end
                n_row[hit_way].age = age_one;
            end
        end else if (r_replace_lru) begin
            sel_way = inv_found ? inv_way : oldest;
            repl    = !inv_found;
            for (int w = 0; w < satl_pkg::WAYS; w++) begin
                n_row[w].age = aged_age[w];
            end
            n_row[sel_way].age = age_one;
        end else begin
            n_lfsr  = lfsr_adv;
            sel_way = rnd_way;
            repl    = !rnd_found;
        end

        if (!hit) begin
            n_row[sel_way].valid = 1'b1;
            n_row[sel_way].tag   = r_s1_tag;
        end

        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (hit) begin
            if (r_hit_cnt != '1) begin
                n_hit_cnt = r_hit_cnt + satl_pkg::CNT_W'(1);
            end
        end else begin
            if (r_miss_cnt != '1) begin
                n_miss_cnt = r_miss_cnt + satl_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= satl_pkg::OFF_W'(4);
            r_index_bits  <= satl_pkg::IDX_W'(6);
            r_replace_lru <= 1'b1;
            r_s1_valid    <= 1'b0;
            r_o_valid     <= 1'b0;
            r_byp         <= 1'b0;
            r_row_valid   <= '0;
            r_lfsr        <= satl_pkg::LFSR_SEED;
            r_hit_cnt     <= '0;
            r_miss_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    satl_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[satl_pkg::OFF_W-1:0];
                    satl_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[satl_pkg::IDX_W-1:0];
                    satl_pkg::CFG_REPLACE_LRU: r_replace_lru <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
                // row being written now is newer than what the ram returns
                r_byp      <= s1_go && (r_s1_set == in_set);
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                r_row_valid[r_s1_set] <= 1'b1;
                r_lfsr                <= n_lfsr;
                r_hit_cnt             <= n_hit_cnt;
                r_miss_cnt            <= n_miss_cnt;
                r_o_valid             <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_set  <= in_set;
            r_s1_tag  <= in_tag;
            r_byp_row <= n_row;
        end
        if (s1_go) begin
            r_hit  <= hit;
            r_way  <= sel_way;
            r_repl <= repl;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_hit            = r_hit;
    assign o_way            = satl_pkg::WAY_OUT_W'(r_way);
    assign o_replaced_valid = r_repl;
    assign o_hit_total      = r_hit_cnt;
    assign o_miss_total     = r_miss_cnt;

endmodule

`default_nettype wire

### design/satl_checker.sv
// port level checks for the cache tag lookup
`default_nettype none

module satl_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_valid,
    input wire logic                            i_ready,
    input wire logic                            o_hit,
    input wire logic [satl_pkg::WAY_OUT_W-1:0]  o_way,
    input wire logic                            o_replaced_valid,
    input wire logic [satl_pkg::CNT_W-1:0]      o_hit_total,
    input wire logic [satl_pkg::CNT_W-1:0]      o_miss_total
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hit) && $stable(o_way)
            && $stable(o_replaced_valid) && $stable(o_hit_total) && $stable(o_miss_total)))
        else $error("result changed while stalled");

    // a hit never evicts
    a_hit_no_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> !o_replaced_valid)
        else $error("hit reported an eviction");

    // back to back results: a hit advances only the hit total
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit && $past(o_valid && i_ready) && $past(i_rst_n))
        |-> (o_miss_total == $past(o_miss_total))
            && ((o_hit_total == $past(o_hit_total) + 32'd1)
                || ($past(o_hit_total) == '1 && o_hit_total == '1)))
        else $error("hit total did not step");

    // back to back results: a miss advances only the miss total
    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit && $past(o_valid && i_ready) && $past(i_rst_n))
        |-> (o_hit_total == $past(o_hit_total))
            && ((o_miss_total == $past(o_miss_total) + 32'd1)
                || ($past(o_miss_total) == '1 && o_miss_total == '1)))
        else $error("miss total did not step");

endmodule

bind set_assoc_cache_tag_lookup_top satl_checker u_satl_checker (.*);

`default_nettype wire

### bench/set_assoc_cache_tag_lookup_top_tb.sv
// cache tag lookup testbench: directed and random address items checked against a directory model
module set_assoc_cache_tag_lookup_top_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TRAFFIC_PHASES = 9;
    localparam int PHASE_ITEMS    = 100;
    // index with no register behind it, the block must ignore the write
    localparam logic [satl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                           hit;
        logic [satl_pkg::WAY_OUT_W-1:0] way;
        logic                           replaced_valid;
        logic [satl_pkg::CNT_W-1:0]     hit_total;
        logic [satl_pkg::CNT_W-1:0]     miss_total;
    } t_lookup_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [satl_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [satl_pkg::CFG_DAT_W-1:0] i_cfg_data;
    logic                           i_valid;
    logic                           o_ready;
    logic [satl_pkg::ADDR_W-1:0]    i_address;
    logic                           o_valid;
    logic                           i_ready;
    logic                           o_hit;
    logic [satl_pkg::WAY_OUT_W-1:0] o_way;
    logic                           o_replaced_valid;
    logic [satl_pkg::CNT_W-1:0]     o_hit_total;
    logic [satl_pkg::CNT_W-1:0]     o_miss_total;

    set_assoc_cache_tag_lookup_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_address        (i_address),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_hit            (o_hit),
        .o_way            (o_way),
        .o_replaced_valid (o_replaced_valid),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total)
    );

    // directory model state
    logic [satl_pkg::TAG_W-1:0]  dir_tag   [satl_pkg::WAYS][satl_pkg::SETS];
    logic                        dir_valid [satl_pkg::WAYS][satl_pkg::SETS];
    logic [satl_pkg::AGE_W-1:0]  dir_age   [satl_pkg::WAYS][satl_pkg::SETS];
    logic [satl_pkg::LFSR_W-1:0] victim_lfsr;
    logic [satl_pkg::CNT_W-1:0]  hit_count;
    logic [satl_pkg::CNT_W-1:0]  miss_count;
    int unsigned                 cfg_offset_bits;
    int unsigned                 cfg_index_bits;
    logic                        cfg_replace_lru;

    t_lookup_result expected_lookups[$];
    t_lookup_result want_result;

    int  error_count     = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  hits_checked    = 0;
    int  settings_used   = 1;
    int  idle_cycles     = 0;
    int  ready_hold      = 0;
    bit  calm            = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 19) < 17)
            return $urandom_range(0, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic reset_directory();
        for (int w = 0; w < satl_pkg::WAYS; w++) begin
            for (int s = 0; s < satl_pkg::SETS; s++) begin
                dir_tag[w][s]   = '0;
                dir_valid[w][s] = 1'b0;
                dir_age[w][s]   = '0;
            end
        end
        victim_lfsr     = satl_pkg::LFSR_SEED;
        hit_count       = '0;
        miss_count      = '0;
        cfg_offset_bits = 4;
        cfg_index_bits  = 6;
        cfg_replace_lru = 1'b1;
    endtask

    // look one address up in the model directory and queue the result it must give
    task automatic lookup_directory(input logic [satl_pkg::ADDR_W-1:0] addr);
        logic [63:0]                addr64;
        logic [63:0]                imask;
        logic [satl_pkg::TAG_W-1:0] tag_v;
        int                         set_idx;
        int                         way;
        int                         probe_start;
        int                         c;
        logic                       hit;
        logic                       repl;
        t_lookup_result             res;
        addr64  = {32'd0, addr};
        imask   = (64'd1 << cfg_index_bits) - 64'd1;
        set_idx = int'(((addr64 >> cfg_offset_bits) & imask) % 64'(satl_pkg::SETS));
        tag_v   = satl_pkg::TAG_W'(addr64 >> (cfg_offset_bits + cfg_index_bits));
        way     = -1;
        hit     = 1'b0;
        repl    = 1'b0;
        for (int w = 0; w < satl_pkg::WAYS; w++) begin
            if (!hit && dir_valid[w][set_idx] && dir_tag[w][set_idx] == tag_v) begin
                way = w;
                hit = 1'b1;
            end
        end
        if (hit) begin
            if (hit_count != '1)
                hit_count++;
            if (cfg_replace_lru) begin
                for (int w = 0; w < satl_pkg::WAYS; w++)
                    if (w != way && dir_valid[w][set_idx]
                        && dir_age[w][set_idx] < satl_pkg::AGE_LIMIT)
                        dir_age[w][set_idx]++;
                dir_age[way][set_idx] = satl_pkg::AGE_W'(1);
            end
        end else begin
            if (miss_count != '1)
                miss_count++;
            if (cfg_replace_lru) begin
                for (int w = 0; w < satl_pkg::WAYS; w++)
                    if (dir_valid[w][set_idx] && dir_age[w][set_idx] < satl_pkg::AGE_LIMIT)
                        dir_age[w][set_idx]++;
                for (int w = 0; w < satl_pkg::WAYS; w++)
                    if (way < 0 && !dir_valid[w][set_idx])
                        way = w;
                if (way < 0) begin
                    // oldest way goes, ties to the highest way
                    way = 0;
                    for (int w = 0; w < satl_pkg::WAYS; w++)
                        if (dir_age[w][set_idx] >= dir_age[way][set_idx])
                            way = w;
                    repl = 1'b1;
                end
                dir_age[way][set_idx] = satl_pkg::AGE_W'(1);
            end else begin
                victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                               victim_lfsr[satl_pkg::LFSR_W-1:1]};
                probe_start = int'(victim_lfsr) % satl_pkg::WAYS;
                for (int k = 0; k < satl_pkg::WAYS; k++) begin
                    c = (probe_start + k) % satl_pkg::WAYS;
                    if (way < 0 && !dir_valid[c][set_idx])
                        way = c;
                end
                if (way < 0) begin
                    way  = probe_start;
                    repl = 1'b1;
                end
            end
            dir_valid[way][set_idx] = 1'b1;
            dir_tag[way][set_idx]   = tag_v;
        end
        res.hit            = hit;
        res.way            = satl_pkg::WAY_OUT_W'(way);
        res.replaced_valid = repl;
        res.hit_total      = hit_count;
        res.miss_total     = miss_count;
        expected_lookups.push_back(res);
    endtask

    // builds an address from tag, set and byte fields under the current widths
    function automatic logic [satl_pkg::ADDR_W-1:0] compose_address(input logic [63:0] tag_v,
                                                                    input logic [63:0] set_v,
                                                                    input logic [63:0] byte_sel);
        logic [63:0] a;
        a = (tag_v << (cfg_offset_bits + cfg_index_bits))
          | ((set_v & ((64'd1 << cfg_index_bits) - 64'd1)) << cfg_offset_bits)
          | (byte_sel & ((64'd1 << cfg_offset_bits) - 64'd1));
        return a[satl_pkg::ADDR_W-1:0];
    endfunction

    // mostly a small working set so that sets fill up, hit and evict
    function automatic logic [satl_pkg::ADDR_W-1:0] make_address();
        logic [63:0] tag_v;
        logic [63:0] set_v;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        tag_v = ($urandom_range(0, 9) == 0) ? 64'($urandom) : 64'($urandom_range(0, 5));
        set_v = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 2));
        return compose_address(tag_v, set_v, 64'($urandom));
    endfunction

    task automatic send_address(input logic [satl_pkg::ADDR_W-1:0] addr);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_address <= addr;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        lookup_directory(addr);
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [satl_pkg::CFG_IDX_W-1:0] idx,
                                input logic [satl_pkg::CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            satl_pkg::CFG_OFFSET_BITS: cfg_offset_bits = 32'(data);
            satl_pkg::CFG_INDEX_BITS:  cfg_index_bits  = 32'(data);
            satl_pkg::CFG_REPLACE_LRU: cfg_replace_lru = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [satl_pkg::CFG_DAT_W-1:0] off,
                                 input logic [satl_pkg::CFG_DAT_W-1:0] idx,
                                 input logic [satl_pkg::CFG_DAT_W-1:0] lru);
        wait_for_results();
        write_config(satl_pkg::CFG_OFFSET_BITS, off);
        write_config(satl_pkg::CFG_INDEX_BITS, idx);
        write_config(satl_pkg::CFG_REPLACE_LRU, lru);
        settings_used++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch on %s at result %0d: got %h expected %h",
                 what, results_checked, got, want);
    endtask

    // reset settings: fill one set past its ways and watch the oldest line go
    task automatic test_lru_fill_and_evict();
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_FFFF);
        for (int t = 1; t <= 4; t++)
            send_address(compose_address(64'(t), 64'd5, 64'd0));
        send_address(compose_address(64'd1, 64'd5, 64'd15));
        send_address(compose_address(64'd5, 64'd5, 64'd3));
        send_address(compose_address(64'd2, 64'd5, 64'd0));
        send_address(compose_address(64'd6, 64'd5, 64'd0));
    endtask

    // zero widths, largest legal widths and widths past the legal range
    task automatic test_field_extremes();
        apply_setting(4'd0, 4'd0, 4'd1);
        send_address(32'hFFFF_FFFF);
        send_address(32'h7FFF_FFFF);
        send_address(32'h0000_0000);
        apply_setting(4'd12, 4'd8, 4'd1);
        send_address(32'hFFFF_FFFF);
        send_address(32'h8000_0FFF);
        apply_setting(4'd15, 4'd15, 4'd1);
        send_address(32'hFFFF_FFFF);
        send_address(32'h8000_0000);
    endtask

    // lfsr victim choice once the set is full, upper data bits must not matter
    task automatic test_random_replacement();
        apply_setting(4'd4, 4'd2, 4'b1110);
        for (int t = 0; t < 6; t++)
            send_address(compose_address(64'(t + 8), 64'd1, 64'(t)));
        send_address(compose_address(64'd13, 64'd1, 64'd0));
        wait_for_results();
        write_config(CFG_UNUSED, 4'b1111);
        write_config(satl_pkg::CFG_REPLACE_LRU, 4'b0001);
        send_address(compose_address(64'd13, 64'd1, 64'd0));
    endtask

    task automatic test_mixed_traffic();
        logic [satl_pkg::CFG_DAT_W-1:0] off;
        logic [satl_pkg::CFG_DAT_W-1:0] idx;
        logic [satl_pkg::CFG_DAT_W-1:0] lru;
        for (int p = 0; p < TRAFFIC_PHASES; p++) begin
            case (p)
                0: begin off = 4'd0;  idx = 4'd8;  lru = 4'd1; end
                1: begin off = 4'd12; idx = 4'd0;  lru = 4'd0; end
                2: begin off = 4'd15; idx = 4'd15; lru = 4'd1; end
                default: begin
                    if ($urandom_range(0, 7) == 0)
                        off = satl_pkg::CFG_DAT_W'($urandom_range(13, 15));
                    else
                        off = satl_pkg::CFG_DAT_W'($urandom_range(0, 12));
                    if ($urandom_range(0, 7) == 0)
                        idx = satl_pkg::CFG_DAT_W'($urandom_range(9, 15));
                    else
                        idx = satl_pkg::CFG_DAT_W'($urandom_range(0, 8));
                    lru = satl_pkg::CFG_DAT_W'($urandom_range(0, 15));
                end
            endcase
            apply_setting(off, idx, lru);
            calm = (p == 3 || p == 7);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off until the pipeline is empty
                if (n == PHASE_ITEMS / 2 && (p % 2) == 0)
                    wait_for_results();
                send_address(make_address());
            end
            calm = 1'b0;
        end
    endtask

    // receiver stalls: runs of ready and runs of back pressure
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (calm || $urandom_range(0, 9) < 7) begin
            i_ready    <= 1'b1;
            ready_hold = $urandom_range(0, 7);
        end else begin
            i_ready    <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_lookups.size() == 0) begin
                report_mismatch("result with none pending", 32'd1, 32'd0);
            end else begin
                want_result = expected_lookups.pop_front();
                if (o_hit !== want_result.hit)
                    report_mismatch("hit", 32'(o_hit), 32'(want_result.hit));
                if (o_way !== want_result.way)
                    report_mismatch("way", 32'(o_way), 32'(want_result.way));
                if (o_replaced_valid !== want_result.replaced_valid)
                    report_mismatch("replaced_valid", 32'(o_replaced_valid),
                                    32'(want_result.replaced_valid));
                if (o_hit_total !== want_result.hit_total)
                    report_mismatch("hit_total", o_hit_total, want_result.hit_total);
                if (o_miss_total !== want_result.miss_total)
                    report_mismatch("miss_total", o_miss_total, want_result.miss_total);
                if (want_result.hit)
                    hits_checked++;
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results pending", expected_lookups.size());
            $display("set_assoc_cache_tag_lookup_top_tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = satl_pkg::CFG_OFFSET_BITS;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_address   = '0;
        i_ready     = 1'b0;
        reset_directory();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_lru_fill_and_evict();
        test_field_extremes();
        test_random_replacement();
        test_mixed_traffic();

        wait_for_results();
        repeat (10) @(posedge i_clk);
        $display("%0d items sent, %0d lookups checked (%0d hits, %0d misses) over %0d settings",
                 items_sent, results_checked, hits_checked, results_checked - hits_checked,
                 settings_used);
        $display("both replacement modes, field widths zero to fifteen, random stalls both sides");
        if (error_count == 0)
            $display("set_assoc_cache_tag_lookup_top_tb passed");
        else
            $display("set_assoc_cache_tag_lookup_top_tb failed");
        $finish;
    end

endmodule
